// ===== design/bfdh_pkg.sv =====
// ============================================================================
// bfdh_pkg
// Shared constants, codes and controller/datapath interface types for the
// double-hash Bloom filter unit.
// ============================================================================
package bfdh_pkg;

    localparam int HASH_COUNT  = 16;
    localparam int STORE_BYTES = 8192;

    localparam int ADDR_W  = $clog2(STORE_BYTES);
    localparam int SIZE_W  = 14;
    localparam int POS_W   = ADDR_W + 3;
    localparam int REM_W   = POS_W;
    localparam int HASH_W  = 64;
    localparam int CNT_W   = $clog2(HASH_W);
    localparam int IDX_W   = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;

    localparam logic [HASH_W-1:0] DJB_INIT = 64'd5381;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_CHECK  = 2'd1;
    localparam logic [1:0] FUNC_MERGE  = 2'd2;

    typedef struct packed {
        logic clr_step;
        logic hash_en;
        logic acc_reset;
        logic probe_load;
        logic mod_step;
        logic probe_rd;
        logic probe_wr;
        logic probe_chk;
        logic probe_adv;
        logic mrg_load;
        logic mrg_rd;
        logic mrg_wr;
        logic out_load;
    } bfdh_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic mod_done;
        logic probe_last;
        logic mrg_ok;
        logic out_free;
    } bfdh_sts_t;

endpackage

// ===== design/bfdh_ctrl.sv =====
// ============================================================================
// bfdh_ctrl
// Sequencer for store clearing, key hashing, probe reduction and merges.
// ============================================================================
module bfdh_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         func,
    input  logic               key_last,
    input  bfdh_pkg::bfdh_sts_t sts,
    output logic               in_stall,
    output bfdh_pkg::bfdh_cmd_t cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_MRG_RD = 4'd2;
    localparam logic [3:0] S_MRG_WR = 4'd3;
    localparam logic [3:0] S_PLOAD  = 4'd4;
    localparam logic [3:0] S_MOD    = 4'd5;
    localparam logic [3:0] S_PRD    = 4'd6;
    localparam logic [3:0] S_PTEST  = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       ins_reg;
    logic       ins_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ins_next   = ins_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == bfdh_pkg::FUNC_MERGE)
                    begin
                        if (sts.mrg_ok)
                        begin
                            cmd.mrg_load = 1'b1;
                            state_next   = S_MRG_RD;
                        end
                    end
                    else if (func == bfdh_pkg::FUNC_INSERT || func == bfdh_pkg::FUNC_CHECK)
                    begin
                        cmd.hash_en = 1'b1;
                        if (key_last)
                        begin
                            ins_next   = (func == bfdh_pkg::FUNC_INSERT);
                            state_next = S_PLOAD;
                        end
                    end
                end
            end
            S_MRG_RD:
            begin
                cmd.mrg_rd = 1'b1;
                state_next = S_MRG_WR;
            end
            S_MRG_WR:
            begin
                cmd.mrg_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_PLOAD:
            begin
                cmd.probe_load = 1'b1;
                state_next     = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_done)
                begin
                    state_next = S_PRD;
                end
            end
            S_PRD:
            begin
                cmd.probe_rd = 1'b1;
                state_next   = S_PTEST;
            end
            S_PTEST:
            begin
                cmd.probe_wr  = ins_reg;
                cmd.probe_chk = !ins_reg;
                if (sts.probe_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.probe_adv = 1'b1;
                    state_next    = S_MOD;
                end
            end
            S_FIN:
            begin
                // A check result waits here until the output register frees up.
                if (ins_reg)
                begin
                    cmd.acc_reset = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.acc_reset = 1'b1;
                    cmd.out_load  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ins_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ins_reg   <= ins_next;
        end
    end

endmodule

// ===== design/bfdh_dp.sv =====
// ============================================================================
// bfdh_dp
// Hash accumulators, bit-serial modulo unit, filter store and result register.
// ============================================================================
module bfdh_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bfdh_pkg::bfdh_cmd_t              cmd,
    output bfdh_pkg::bfdh_sts_t              sts,
    input  logic [bfdh_pkg::SIZE_W-1:0]      eff_bytes,
    input  logic [7:0]                       key_byte,
    input  logic [12:0]                      merge_index,
    input  logic [7:0]                       merge_data,
    input  logic                             out_stall,
    output logic                             out_valid,
    output logic                             present
);

    localparam int HW = bfdh_pkg::HASH_W;
    localparam int AW = bfdh_pkg::ADDR_W;
    localparam int RW = bfdh_pkg::REM_W;
    localparam int IW = bfdh_pkg::IDX_W;
    localparam int CW = bfdh_pkg::CNT_W;

    logic [7:0]    mem [bfdh_pkg::STORE_BYTES];
    logic [7:0]    rd_q;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic [HW-1:0] djb_reg;
    logic [HW-1:0] sdbm_reg;
    logic [HW-1:0] c_ext;
    logic [HW-1:0] h_reg;
    logic [HW-1:0] h_next;
    logic [HW-1:0] dvd_reg;
    logic [RW-1:0] rem_reg;
    logic [RW:0]   rem_trial;
    logic [RW:0]   modulus;
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] idx_reg;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] mrg_idx_reg;
    logic [7:0]    mrg_data_reg;
    logic          all_reg;
    logic          out_valid_reg;
    logic          present_reg;
    logic [AW-1:0] probe_addr;
    logic [7:0]    probe_mask;

    assign c_ext     = {{(HW-8){key_byte[7]}}, key_byte};
    assign modulus   = {eff_bytes, 3'b000};
    assign rem_trial = {rem_reg, dvd_reg[HW-1]};
    assign h_next    = h_reg + sdbm_reg + HW'({idx_reg, 1'b1});
    assign probe_addr = rem_reg[RW-1:3];
    assign probe_mask = 8'(1) << rem_reg[2:0];

    assign sts.clr_done   = (clr_reg == AW'(bfdh_pkg::STORE_BYTES - 1));
    assign sts.mod_done   = (cnt_reg == CW'(HW - 1));
    assign sts.probe_last = (idx_reg == IW'(bfdh_pkg::HASH_COUNT - 1));
    assign sts.mrg_ok     = ({1'b0, merge_index} < eff_bytes);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign present   = present_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = probe_addr;
        mem_wdata = rd_q | probe_mask;
        mem_raddr = probe_addr;
        if (cmd.clr_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = 8'd0;
        end
        else if (cmd.mrg_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = mrg_idx_reg;
            mem_wdata = rd_q | mrg_data_reg;
        end
        else if (cmd.probe_wr)
        begin
            mem_we = 1'b1;
        end
        if (cmd.mrg_rd)
        begin
            mem_raddr = mrg_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.probe_rd || cmd.mrg_rd)
        begin
            rd_q <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mrg_load)
        begin
            mrg_idx_reg  <= merge_index;
            mrg_data_reg <= merge_data;
        end
        if (cmd.probe_load)
        begin
            h_reg   <= djb_reg;
            dvd_reg <= djb_reg;
            rem_reg <= '0;
        end
        else if (cmd.probe_adv)
        begin
            h_reg   <= h_next;
            dvd_reg <= h_next;
            rem_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            dvd_reg <= {dvd_reg[HW-2:0], 1'b0};
            if (rem_trial >= modulus)
            begin
                rem_reg <= RW'(rem_trial - modulus);
            end
            else
            begin
                rem_reg <= RW'(rem_trial);
            end
        end
        if (cmd.out_load)
        begin
            present_reg <= all_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            djb_reg       <= bfdh_pkg::DJB_INIT;
            sdbm_reg      <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            clr_reg       <= '0;
            all_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.hash_en)
            begin
                djb_reg  <= (djb_reg << 5) + djb_reg + c_ext;
                sdbm_reg <= (sdbm_reg << 16) + (sdbm_reg << 6) - sdbm_reg + c_ext;
            end
            else if (cmd.acc_reset)
            begin
                djb_reg  <= bfdh_pkg::DJB_INIT;
                sdbm_reg <= '0;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.probe_load || cmd.probe_adv)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.mod_step)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.probe_load)
            begin
                idx_reg <= '0;
                all_reg <= 1'b1;
            end
            else
            begin
                if (cmd.probe_adv)
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
                if (cmd.probe_chk && ((rd_q & probe_mask) == 8'd0))
                begin
                    all_reg <= 1'b0;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== design/bloom_filter_double_hash_unit.sv =====
// ============================================================================
// bloom_filter_double_hash_unit
// Bloom filter with djb2/sdbm double hashing over an on-chip byte store.
// ============================================================================
// A non-final key byte updates both hashes; an in-range merge ORs its data
// into the addressed byte; a final key byte runs the bit-serial modulo unit,
// which reduces each of the 16 probe hashes one bit per cycle, then sets or
// tests that probe's bit. One transaction at a time; the next is taken once
// the sequencer is back in its idle state. After reset the 8192-byte store
// is swept to zero, one byte per cycle, before the first transaction is taken.
module bloom_filter_double_hash_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  key_byte,
    input  logic        key_last,
    input  logic [12:0] merge_index,
    input  logic [7:0]  merge_data,
    // Result channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic        present
);

    localparam int SW = bfdh_pkg::SIZE_W;

    logic [SW-1:0]       bloom_bytes_reg;
    logic [SW-1:0]       eff_bytes;
    bfdh_pkg::bfdh_cmd_t cmd;
    bfdh_pkg::bfdh_sts_t sts;

    // Only register 0 exists; the upper address bit selects unmapped space.
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-SW){1'b0}}, bloom_bytes_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bloom_bytes_reg <= SW'(8192);
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            bloom_bytes_reg <= pwdata[SW-1:0];
        end
    end

    // The effective size saturates into the range of the store; zero acts as one.
    always_comb
    begin
        if (bloom_bytes_reg == '0)
        begin
            eff_bytes = SW'(1);
        end
        else if (bloom_bytes_reg > SW'(bfdh_pkg::STORE_BYTES))
        begin
            eff_bytes = SW'(bfdh_pkg::STORE_BYTES);
        end
        else
        begin
            eff_bytes = bloom_bytes_reg;
        end
    end

    // The controller sequences clearing, hashing, probing and merges; the
    // datapath holds the hashes, the modulo unit and the store.
    bfdh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .key_last (key_last),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    bfdh_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .eff_bytes   (eff_bytes),
        .key_byte    (key_byte),
        .merge_index (merge_index),
        .merge_data  (merge_data),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .present     (present)
    );

endmodule
